// File: design/wmm_pkg.sv
// shared widths, constants and stage bundle for the wavelet modulus maxima cascade
`default_nettype none

package wmm_pkg;

    // sample and cascade geometry
    localparam int SAMPLE_W      = 16;
    localparam int LEVELS        = 4;
    localparam int LVL_W         = $clog2(LEVELS);
    localparam int LINE_W        = SAMPLE_W + 9;   // widest approximation kept in a line
    localparam int ACC_W         = SAMPLE_W + 13;  // widest detail value
    localparam int DEPTH         = 24;             // deepest tap line
    localparam int WARMUP        = 24;
    localparam int LEVEL1_START  = 3;
    localparam int CNT_W         = $clog2(WARMUP + 1);

    // result field widths
    localparam int D1_W          = SAMPLE_W + 4;
    localparam int D2_W          = SAMPLE_W + 7;
    localparam int D3_W          = SAMPLE_W + 10;
    localparam int D4_W          = SAMPLE_W + 13;
    localparam int OUT_W         = 2 * (D1_W + D2_W + D3_W + D4_W);

    // stream bus widths, rounded up to whole bytes
    localparam int IN_TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((OUT_W + 7) / 8) * 8;

    typedef logic [LINE_W-1:0] line_t;
    typedef logic [ACC_W-1:0]  acc_t;

    // what one cell hands to the next
    typedef struct packed {
        logic                   on1;
        logic                   deep;
        line_t                  approx;
        acc_t [LEVELS-1:0]      detail;
        acc_t [LEVELS-1:0]      peak;
    } stage_t;

    // sign extend a line value to the accumulator width
    function automatic acc_t widen(line_t x);
        return {{(ACC_W - LINE_W){x[LINE_W-1]}}, x};
    endfunction

    // three times a value, shift and add
    function automatic acc_t times3(acc_t x);
        return (x << 1) + x;
    endfunction

endpackage

`default_nettype wire

// File: design/wmm_cell.sv
// one cascade level: tap line, filter pair and extremum marking
`default_nettype none

module wmm_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [wmm_pkg::LVL_W-1:0]  level,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire wmm_pkg::stage_t            in_stage,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output wmm_pkg::stage_t                 out_stage
);
    import wmm_pkg::*;

    line_t   line_reg [DEPTH];
    acc_t    prev_detail_reg;
    logic    prev_rise_reg;
    logic    prev_fall_reg;
    logic    valid_reg;
    stage_t  stage_reg;

    acc_t    t0;
    acc_t    t1;
    acc_t    t2;
    acc_t    t3;
    logic    en;
    acc_t    approx_sum;
    acc_t    detail_sum;
    logic    rise;
    logic    fall;
    logic    mark;
    logic    take;
    stage_t  stage_next;

    // stage handshake, a bubble is always refilled
    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

    // taps spaced 1, 2, 4 or 8 beats apart by level
    always_comb
    begin
        t0 = widen(in_stage.approx);
        case (level)
            2'd0:
            begin
                t1 = widen(line_reg[0]);
                t2 = widen(line_reg[1]);
                t3 = widen(line_reg[2]);
            end
            2'd1:
            begin
                t1 = widen(line_reg[1]);
                t2 = widen(line_reg[3]);
                t3 = widen(line_reg[5]);
            end
            2'd2:
            begin
                t1 = widen(line_reg[3]);
                t2 = widen(line_reg[7]);
                t3 = widen(line_reg[11]);
            end
            default:
            begin
                t1 = widen(line_reg[7]);
                t2 = widen(line_reg[15]);
                t3 = widen(line_reg[23]);
            end
        endcase
    end

    // quadratic spline pair, forced to zero during warm-up
    always_comb
    begin
        en = (level == '0) ? in_stage.on1 : in_stage.deep;
        if (en)
        begin
            approx_sum = t0 + times3(t1) + times3(t2) + t3;
            detail_sum = t3 + times3(t2) - times3(t1) - t0;
        end
        else
        begin
            approx_sum = '0;
            detail_sum = '0;
        end
    end

    // rise, fall and extremum of the previous beat
    always_comb
    begin
        rise = ($signed(detail_sum) > 0) && ($signed(detail_sum) > $signed(prev_detail_reg));
        fall = ($signed(detail_sum) < 0) && ($signed(detail_sum) < $signed(prev_detail_reg));
        mark = (prev_rise_reg && !rise) || (prev_fall_reg && !fall);
        stage_next               = in_stage;
        stage_next.approx        = approx_sum[LINE_W-1:0];
        stage_next.detail[level] = detail_sum;
        stage_next.peak[level]   = mark ? prev_detail_reg : '0;
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= stage_next;
        end
    end

    // tap line and extremum history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_reg[i] <= '0;
            end
            prev_detail_reg <= '0;
            prev_rise_reg   <= 1'b0;
            prev_fall_reg   <= 1'b0;
        end
        else if (take)
        begin
            line_reg[0] <= in_stage.approx;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
            prev_detail_reg <= detail_sum;
            prev_rise_reg   <= rise;
            prev_fall_reg   <= fall;
        end
    end

    // a level held off by warm-up leaves a zero detail
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !en) |=> (stage_reg.detail[level] == '0))
        else $error("warm-up level produced nonzero detail");

    // a peak only follows a rising or falling beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !prev_rise_reg && !prev_fall_reg) |=> (stage_reg.peak[level] == '0))
        else $error("peak without prior rise or fall");

    // a beat never both rises and falls
    assert property (@(posedge clk) disable iff (!rst_n)
        !(prev_rise_reg && prev_fall_reg))
        else $error("rise and fall both set");

endmodule

`default_nettype wire

// File: design/wavelet_modulus_maxima_4_level.sv
// top level: four-level a trous wavelet cascade with modulus maxima marking
//
// Usage: one signed sample enters per beat on the s_axis channel; every
// accepted beat yields exactly one result beat on the m_axis channel that
// carries the four detail values of that sample and, one sample late, the
// four details kept only at local maxima or minima.
// An accepted input beat passes one register stage per level cell on its
// way to m_axis_tvalid. Throughput: one beat per cycle while m_axis_tready
// stays high. The row holds four level cells, each one filter pair and
// compare deep, with the last cell's register as the output register.
// Reset clears all tap lines, extremum history and the warm-up counter, so
// level 1 reads zero for the first three samples and deeper levels for the
// first 24. When the receiver stalls, a held result stays on m_axis while
// empty cells upstream keep taking beats; s_axis_tready drops only once
// every cell holds a beat. Results are never lost or repeated.
`default_nettype none

module wavelet_modulus_maxima_4_level (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // sample
    input  wire logic [wmm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // detail_one, detail_two, detail_three, detail_four,
    // peak_one, peak_two, peak_three, peak_four, zero fill
    output logic [wmm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
    import wmm_pkg::*;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              take_in;
    stage_t            chain [LEVELS+1];
    logic              chain_valid [LEVELS+1];
    logic              chain_ready [LEVELS+1];
    stage_t            last;

    assign take_in = s_axis_tvalid && s_axis_tready;

    // warm-up counter, saturates
    always_comb
    begin
        cnt_next = cnt_reg;
        if (take_in && (cnt_reg < CNT_W'(WARMUP)))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // input beat into the first cell
    always_comb
    begin
        chain[0]        = '0;
        chain[0].on1    = cnt_reg >= CNT_W'(LEVEL1_START);
        chain[0].deep   = cnt_reg >= CNT_W'(WARMUP);
        chain[0].approx = {{(LINE_W - SAMPLE_W){s_axis_tdata[SAMPLE_W-1]}},
                           s_axis_tdata[SAMPLE_W-1:0]};
    end

    assign chain_valid[0]      = s_axis_tvalid;
    assign s_axis_tready       = chain_ready[0];
    assign chain_ready[LEVELS] = m_axis_tready;

    // row of level cells
    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        wmm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .level     (LVL_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_stage  (chain[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_stage (chain[i+1])
        );
    end

    // result beat
    assign last          = chain[LEVELS];
    assign m_axis_tvalid = chain_valid[LEVELS];
    assign m_axis_tdata  = {
        {(OUT_TDATA_W - OUT_W){1'b0}},
        last.peak[3][D4_W-1:0],
        last.peak[2][D3_W-1:0],
        last.peak[1][D2_W-1:0],
        last.peak[0][D1_W-1:0],
        last.detail[3][D4_W-1:0],
        last.detail[2][D3_W-1:0],
        last.detail[1][D2_W-1:0],
        last.detail[0][D1_W-1:0]
    };

    // counter never passes the warm-up length
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(WARMUP))
        else $error("warm-up counter overran");

    // every accepted beat during warm-up advances the counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (take_in && (cnt_reg < CNT_W'(WARMUP))) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("warm-up counter missed a beat");

    // a stalled result beat holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

`default_nettype wire

// File: verif/wavelet_modulus_maxima_4_level_test.sv
// stream testbench for the four-level wavelet modulus maxima cascade
module wavelet_modulus_maxima_4_level_test;

    import wmm_pkg::*;

    // result beat laid out as on m_axis_tdata, detail_one in the lowest bits
    typedef struct packed {
        logic [D4_W-1:0] peak_four;
        logic [D3_W-1:0] peak_three;
        logic [D2_W-1:0] peak_two;
        logic [D1_W-1:0] peak_one;
        logic [D4_W-1:0] detail_four;
        logic [D3_W-1:0] detail_three;
        logic [D2_W-1:0] detail_two;
        logic [D1_W-1:0] detail_one;
    } result_beat_t;

    // random sample shapes
    typedef enum int {SHAPE_WAVE, SHAPE_FULL, SHAPE_NOISE, SHAPE_EXTREME} shape_t;

    // cascade predictor and queue of expected result beats
    class wavelet_scoreboard;
        logic signed [SAMPLE_W-1:0]   x_line[3];
        logic signed [SAMPLE_W+2:0]   a1_line[6];
        logic signed [SAMPLE_W+5:0]   a2_line[12];
        logic signed [SAMPLE_W+8:0]   a3_line[24];
        logic signed [ACC_W-1:0]      prev_detail[LEVELS];
        bit                           prev_rise[LEVELS];
        bit                           prev_fall[LEVELS];
        int                           samples_seen;
        result_beat_t                 expected_beats[$];
        int                           errors;

        function new();
            foreach (x_line[i]) x_line[i] = '0;
            foreach (a1_line[i]) a1_line[i] = '0;
            foreach (a2_line[i]) a2_line[i] = '0;
            foreach (a3_line[i]) a3_line[i] = '0;
            foreach (prev_detail[i])
            begin
                prev_detail[i] = '0;
                prev_rise[i] = 1'b0;
                prev_fall[i] = 1'b0;
            end
            samples_seen = 0;
            errors = 0;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        // accepted sample beat: advance the cascade and queue its result
        function void note_sample(logic signed [SAMPLE_W-1:0] s);
            longint x0;
            longint a0;
            longint a1;
            longint a2;
            longint d[LEVELS];
            longint p[LEVELS];
            bit rise;
            bit fall;
            bit mark;
            result_beat_t beat;
            x0 = longint'(s);
            // level 1, off during its warm-up
            if (samples_seen >= LEVEL1_START)
            begin
                a0 = x0 + 3 * x_line[0] + 3 * x_line[1] + x_line[2];
                d[0] = -x0 - 3 * x_line[0] + 3 * x_line[1] + x_line[2];
            end
            else
            begin
                a0 = 0;
                d[0] = 0;
            end
            // levels 2 to 4, off until the long warm-up is over
            if (samples_seen >= WARMUP)
            begin
                a1 = a0 + 3 * a1_line[1] + 3 * a1_line[3] + a1_line[5];
                d[1] = -a0 - 3 * a1_line[1] + 3 * a1_line[3] + a1_line[5];
                a2 = a1 + 3 * a2_line[3] + 3 * a2_line[7] + a2_line[11];
                d[2] = -a1 - 3 * a2_line[3] + 3 * a2_line[7] + a2_line[11];
                d[3] = -a2 - 3 * a3_line[7] + 3 * a3_line[15] + a3_line[23];
            end
            else
            begin
                a1 = 0;
                a2 = 0;
                d[1] = 0;
                d[2] = 0;
                d[3] = 0;
            end
            // shift the tap lines, newest in front
            for (int i = 2; i > 0; i--) x_line[i] = x_line[i-1];
            x_line[0] = s;
            for (int i = 5; i > 0; i--) a1_line[i] = a1_line[i-1];
            a1_line[0] = (SAMPLE_W+3)'(a0);
            for (int i = 11; i > 0; i--) a2_line[i] = a2_line[i-1];
            a2_line[0] = (SAMPLE_W+6)'(a1);
            for (int i = 23; i > 0; i--) a3_line[i] = a3_line[i-1];
            a3_line[0] = (SAMPLE_W+9)'(a2);
            // mark the previous sample where its rise or fall ends
            for (int k = 0; k < LEVELS; k++)
            begin
                rise = d[k] > 0 && d[k] > prev_detail[k];
                fall = d[k] < 0 && d[k] < prev_detail[k];
                mark = (prev_rise[k] && !rise) || (prev_fall[k] && !fall);
                p[k] = mark ? longint'(prev_detail[k]) : 0;
                prev_detail[k] = ACC_W'(d[k]);
                prev_rise[k] = rise;
                prev_fall[k] = fall;
            end
            if (samples_seen < WARMUP)
                samples_seen++;
            beat.detail_one   = d[0][D1_W-1:0];
            beat.detail_two   = d[1][D2_W-1:0];
            beat.detail_three = d[2][D3_W-1:0];
            beat.detail_four  = d[3][D4_W-1:0];
            beat.peak_one     = p[0][D1_W-1:0];
            beat.peak_two     = p[1][D2_W-1:0];
            beat.peak_three   = p[2][D3_W-1:0];
            beat.peak_four    = p[3][D4_W-1:0];
            expected_beats.push_back(beat);
        endfunction

        task compare_field(string name, logic [ACC_W-1:0] got, logic [ACC_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // accepted result beat against the oldest expectation
        task check_result(logic [OUT_TDATA_W-1:0] tdata);
            result_beat_t got;
            result_beat_t want;
            if (expected_beats.size() == 0)
            begin
                report("result beat with no sample waiting");
                return;
            end
            want = expected_beats.pop_front();
            got = tdata[OUT_W-1:0];
            compare_field("detail_one", ACC_W'(got.detail_one), ACC_W'(want.detail_one));
            compare_field("detail_two", ACC_W'(got.detail_two), ACC_W'(want.detail_two));
            compare_field("detail_three", ACC_W'(got.detail_three),
                          ACC_W'(want.detail_three));
            compare_field("detail_four", ACC_W'(got.detail_four), ACC_W'(want.detail_four));
            compare_field("peak_one", ACC_W'(got.peak_one), ACC_W'(want.peak_one));
            compare_field("peak_two", ACC_W'(got.peak_two), ACC_W'(want.peak_two));
            compare_field("peak_three", ACC_W'(got.peak_three), ACC_W'(want.peak_three));
            compare_field("peak_four", ACC_W'(got.peak_four), ACC_W'(want.peak_four));
            if (tdata[OUT_TDATA_W-1:OUT_W] !== '0)
                report("zero fill bits set");
        endtask
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    // sample
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    // detail_one .. detail_four, peak_one .. peak_four, zero fill
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;

    wavelet_scoreboard          sb;
    int                         send_idle_pct;
    int                         recv_stall_pct;
    shape_t                     shape;
    int                         shape_left;
    longint                     wave_level;
    longint                     wave_slope;
    int                         directed_samples[$] = '{
        0, 32767, -32768, 32767, -32768, 0, 0, 0, 1, -1, 0,
        100, 200, 300, 200, 100, 0, -100, -200, -300, -200, -100, 0, 0, 0
    };
    int                         phase_send_pct[4] = '{0, 75, 0, 21};
    int                         phase_recv_pct[4] = '{0, 0, 75, 21};

    wavelet_modulus_maxima_4_level dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // next random sample, shapes picked in runs
    function logic signed [SAMPLE_W-1:0] make_sample();
        longint v;
        int pick;
        if (shape_left == 0)
        begin
            pick = $urandom_range(0, 99);
            shape = pick < 60 ? SHAPE_WAVE : pick < 75 ? SHAPE_FULL :
                    pick < 90 ? SHAPE_NOISE : SHAPE_EXTREME;
            shape_left = $urandom_range(20, 60);
        end
        shape_left--;
        case (shape)
            SHAPE_WAVE:
            begin
                // smooth ramps with the odd steep change of slope
                if ($urandom_range(0, 15) == 0)
                    wave_slope = longint'($urandom_range(0, 4000)) - 2000;
                if ($urandom_range(0, 49) == 0)
                    wave_slope = longint'($urandom_range(0, 24000)) - 12000;
                wave_level = wave_level + wave_slope;
                if (wave_level > 32767)
                begin
                    wave_level = 32767;
                    wave_slope = -wave_slope;
                end
                if (wave_level < -32768)
                begin
                    wave_level = -32768;
                    wave_slope = -wave_slope;
                end
                v = wave_level + longint'($urandom_range(0, 6)) - 3;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end
            SHAPE_FULL: v = longint'($urandom);
            SHAPE_NOISE: v = longint'($urandom_range(0, 16)) - 8;
            default:
            begin
                pick = $urandom_range(0, 3);
                v = pick == 0 ? 32767 : pick == 1 ? -32768 : pick == 2 ? 0 : -1;
            end
        endcase
        return v[SAMPLE_W-1:0];
    endfunction

    // present one sample beat and hold it until accepted
    task send_sample(logic signed [SAMPLE_W-1:0] v);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= IN_TDATA_W'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= v;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_sample(v);
    endtask

    // receiver back-pressure
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result beat monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // run limit
    initial
    begin
        repeat (400000) @(posedge clk);
        $display("wavelet_modulus_maxima_4_level_test: errors");
        $finish;
    end

    // main sequence
    initial
    begin
        int drain_cycles;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shape = SHAPE_WAVE;
        shape_left = 0;
        wave_level = 0;
        wave_slope = 500;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, impulses and a small bump through warm-up
        foreach (directed_samples[i])
            send_sample(SAMPLE_W'(directed_samples[i]));

        // random phases with different idling
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = phase_send_pct[phase];
            recv_stall_pct = phase_recv_pct[phase];
            for (int i = 0; i < 350; i++)
            begin
                // sender holds off until every result is out
                if (phase == 1 && i == 175)
                begin
                    @(negedge clk);
                    s_axis_tvalid <= 1'b0;
                    do @(posedge clk); while (sb.pending() != 0);
                end
                send_sample(make_sample());
            end
        end

        // drain
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        drain_cycles = 0;
        while (sb.pending() != 0 && drain_cycles < 20000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        if (sb.pending() != 0)
            sb.report("samples left without a result beat");
        repeat (12) @(posedge clk);
        @(negedge clk);
        if (sb.errors == 0)
            $display("wavelet_modulus_maxima_4_level_test: clean");
        else
            $display("wavelet_modulus_maxima_4_level_test: errors");
        $finish;
    end

endmodule
